// ===== sv/adc_map_pixel_defines.svh =====
// Assertion macros for the ADC map pixel block.
`ifndef ADC_MAP_PIXEL_DEFINES_SVH
`define ADC_MAP_PIXEL_DEFINES_SVH

`ifndef SYNTHESIS

// ante implies cons in the same cycle
`define ADCMP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("adc_map_pixel: same-cycle check failed");

// ante implies cons in the next cycle
`define ADCMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("adc_map_pixel: next-cycle check failed");

`else

`define ADCMP_ASSERT_SAME(label, clk, rst, ante, cons)
`define ADCMP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/adcmp_pkg.sv =====
// Shared types and constants for the ADC map pixel block.
`default_nettype none

package adcmp_pkg;

   localparam int SAMPLE_W          = 16;
   localparam int ADC_W             = 16;
   localparam int B_VALUE_W         = 14;
   localparam int MUL_W             = 32;
   localparam int MANT_W            = 31;
   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int LOG_FRAC_BITS_DEF = 16;

   localparam logic [B_VALUE_W-1:0] B_VALUE_RESET = B_VALUE_W'(1000);
   localparam logic [MUL_W-1:0]     LN2_Q32       = 32'd2977044472;
   localparam logic [ADC_W-1:0]     ADC_MAX       = '1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_NORM,
      S_SQUARE,
      S_LN,
      S_SCALE,
      S_OUT
   } state_type;

endpackage

`default_nettype wire

// ===== sv/adcmp_if.sv =====
// Valid/ready channel interfaces for the ADC map pixel block.
`default_nettype none

interface adcmp_req_if import adcmp_pkg::*;;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] baseline_sample;
   logic [SAMPLE_W-1:0] weighted_sample;
   logic                last_voxel;

   modport source (output valid, output baseline_sample, output weighted_sample,
                   output last_voxel, input ready);
   modport sink   (input valid, input baseline_sample, input weighted_sample,
                   input last_voxel, output ready);
endinterface

interface adcmp_rsp_if import adcmp_pkg::*;;
   logic             valid;
   logic             ready;
   logic [ADC_W-1:0] adc_value;
   logic [ADC_W-1:0] running_max;
   logic             volume_done;

   modport source (output valid, output adc_value, output running_max,
                   output volume_done, input ready);
   modport sink   (input valid, input adc_value, input running_max,
                   input volume_done, output ready);
endinterface

interface adcmp_csr_if import adcmp_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [B_VALUE_W-1:0] b_value;

   modport source (output valid, output b_value, input ready);
   modport sink   (input valid, input b_value, output ready);
endinterface

`default_nettype wire

// ===== sv/adc_map_pixel.sv =====
// ADC map voxel unit: scaled log ratio of baseline over weighted sample.
//
// req_if carries one voxel (baseline, weighted, last flag) per transfer; rsp_if
// returns one result per voxel in order: adc_value, the running maximum of the
// volume including this voxel, and volume_done. csr_if writes b_value, always
// ready; write it only while the block is idle.
// A voxel with a zero sample goes from idle straight to the output state and
// gives a zero result. Otherwise two fixed-point log2 runs (each a normalize
// step and a squaring loop on the shared 32x32 multiplier), one ln 2 scaling
// and one b-value multiply give the result.
// One voxel is in work at a time: req_if.ready is high only while idle, so a
// new voxel is taken only once the last one has left the sequencer.
// The result sits in an output register; a new voxel is accepted while it
// waits. If the receiver stalls, the next finished result holds in the
// sequencer until the register frees.
// Reset clears the sequencer, the output valid, the running maximum and sets
// b_value to 1000. The running maximum clears after the last voxel's result.
`default_nettype none
`include "adc_map_pixel_defines.svh"

module adc_map_pixel import adcmp_pkg::*; #(
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   adcmp_req_if.sink   req_if,
   adcmp_rsp_if.source rsp_if,
   adcmp_csr_if.sink   csr_if
);

   localparam int EXP_W = $clog2(SAMPLE_BITS);
   localparam int LG_W  = EXP_W + LOG_FRAC_BITS;
   localparam int CNT_W = $clog2(LOG_FRAC_BITS);
   localparam int R_W   = B_VALUE_W + EXP_W;
   localparam int P_W   = 2 * MUL_W;

   state_type                state_ff, state_in;
   logic [B_VALUE_W-1:0]     b_value_ff, b_value_in;
   logic [SAMPLE_BITS-1:0]   base_ff, base_in, wgt_ff, wgt_in;
   logic                     last_ff, last_in, zero_ff, zero_in, phase_ff, phase_in;
   logic [MANT_W-1:0]        m_ff, m_in;
   logic [EXP_W-1:0]         exp_ff, exp_in;
   logic [LOG_FRAC_BITS-1:0] frac_ff, frac_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [LG_W-1:0]          lg_base_ff, lg_base_in, diff_ff, diff_in;
   logic [P_W-1:0]           prod_ff, prod_in;
   logic [ADC_W-1:0]         max_ff, max_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ADC_W-1:0]         adc_out_ff, adc_out_in, max_out_ff, max_out_in;
   logic                     done_ff, done_in;

   logic [SAMPLE_BITS-1:0]   base_masked, wgt_masked, wgt_clamped, norm_src;
   logic [EXP_W-1:0]         norm_exp;
   logic [MANT_W-1:0]        norm_mant, sq_mant;
   logic [MUL_W-1:0]         mul_a, mul_b, sq;
   logic [P_W-1:0]           product;
   logic                     sq_bit;
   logic [LOG_FRAC_BITS-1:0] frac_next;
   logic [LG_W-1:0]          lg_now;
   logic [R_W-1:0]           r_full;
   logic [ADC_W-1:0]         adc_calc, new_max;
   logic                     req_xfer, load;

   assign req_if.ready       = (state_ff == S_IDLE);
   assign csr_if.ready       = 1'b1;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.adc_value   = adc_out_ff;
   assign rsp_if.running_max = max_out_ff;
   assign rsp_if.volume_done = done_ff;

   assign req_xfer = req_if.valid && req_if.ready;

   // shared multiplier
   assign product = P_W'(mul_a) * P_W'(mul_b);

   always_comb begin
      base_masked = req_if.baseline_sample[SAMPLE_BITS-1:0];
      wgt_masked  = req_if.weighted_sample[SAMPLE_BITS-1:0];
      wgt_clamped = (wgt_masked > base_masked) ? base_masked : wgt_masked;

      norm_src = phase_ff ? wgt_ff : base_ff;
      norm_exp = '0;
      for (int i = 0; i < SAMPLE_BITS; i++) begin
         if (norm_src[i]) norm_exp = EXP_W'(i);
      end
      norm_mant = MANT_W'(norm_src) << (MANT_W - 1 - int'(norm_exp));

      unique case (state_ff)
         S_LN: begin
            mul_a = MUL_W'(diff_ff);
            mul_b = LN2_Q32;
         end
         S_SCALE: begin
            mul_a = MUL_W'(b_value_ff);
            mul_b = MUL_W'(prod_ff[MUL_W +: LG_W]);
         end
         default: begin
            mul_a = MUL_W'(m_ff);
            mul_b = MUL_W'(m_ff);
         end
      endcase

      // m*m in Q1.30; top bit set means the square reached 2
      sq        = product[MANT_W-1 +: MUL_W];
      sq_bit    = sq[MUL_W-1];
      sq_mant   = sq_bit ? sq[MUL_W-1:1] : sq[MANT_W-1:0];
      frac_next = {frac_ff[LOG_FRAC_BITS-2:0], sq_bit};
      lg_now    = {exp_ff, frac_next};

      r_full   = prod_ff[LOG_FRAC_BITS +: R_W];
      adc_calc = zero_ff ? '0 :
                 ((|r_full[R_W-1:ADC_W]) ? ADC_MAX : r_full[ADC_W-1:0]);
      new_max  = (adc_calc > max_ff) ? adc_calc : max_ff;
   end

   always_comb begin
      state_in   = state_ff;
      b_value_in = csr_if.valid ? csr_if.b_value : b_value_ff;
      base_in    = base_ff;
      wgt_in     = wgt_ff;
      last_in    = last_ff;
      zero_in    = zero_ff;
      phase_in   = phase_ff;
      m_in       = m_ff;
      exp_in     = exp_ff;
      frac_in    = frac_ff;
      cnt_in     = cnt_ff;
      lg_base_in = lg_base_ff;
      diff_in    = diff_ff;
      prod_in    = prod_ff;
      max_in     = max_ff;
      load       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               base_in  = base_masked;
               wgt_in   = wgt_clamped;
               last_in  = req_if.last_voxel;
               zero_in  = (base_masked == '0) || (wgt_masked == '0);
               phase_in = 1'b0;
               state_in = ((base_masked == '0) || (wgt_masked == '0)) ? S_OUT : S_NORM;
            end
         end
         S_NORM: begin
            m_in     = norm_mant;
            exp_in   = norm_exp;
            frac_in  = '0;
            cnt_in   = '0;
            state_in = S_SQUARE;
         end
         S_SQUARE: begin
            m_in    = sq_mant;
            frac_in = frac_next;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(LOG_FRAC_BITS - 1)) begin
               if (!phase_ff) begin
                  lg_base_in = lg_now;
                  phase_in   = 1'b1;
                  state_in   = S_NORM;
               end else begin
                  diff_in  = (lg_base_ff > lg_now) ? (lg_base_ff - lg_now) : '0;
                  state_in = S_LN;
               end
            end
         end
         S_LN: begin
            prod_in  = product;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            prod_in  = product;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               load     = 1'b1;
               max_in   = last_ff ? '0 : new_max;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      adc_out_in   = adc_out_ff;
      max_out_in   = max_out_ff;
      done_in      = done_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         adc_out_in   = adc_calc;
         max_out_in   = new_max;
         done_in      = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         b_value_ff   <= B_VALUE_RESET;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         b_value_ff   <= b_value_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff    <= base_in;
      wgt_ff     <= wgt_in;
      last_ff    <= last_in;
      zero_ff    <= zero_in;
      phase_ff   <= phase_in;
      m_ff       <= m_in;
      exp_ff     <= exp_in;
      frac_ff    <= frac_in;
      cnt_ff     <= cnt_in;
      lg_base_ff <= lg_base_in;
      diff_ff    <= diff_in;
      prod_ff    <= prod_in;
      adc_out_ff <= adc_out_in;
      max_out_ff <= max_out_in;
      done_ff    <= done_in;
   end

   `ADCMP_ASSERT_SAME(a_mant_norm, clock, reset, state_ff == S_SQUARE, m_ff[MANT_W-1])
   `ADCMP_ASSERT_SAME(a_cnt_range, clock, reset, state_ff == S_SQUARE,
      cnt_ff <= CNT_W'(LOG_FRAC_BITS - 1))
   `ADCMP_ASSERT_SAME(a_max_ge_adc, clock, reset, rsp_valid_ff,
      max_out_ff >= adc_out_ff)
   `ADCMP_ASSERT_NEXT(a_max_clear, clock, reset, load && last_ff, max_ff == '0)
   `ADCMP_ASSERT_NEXT(a_busy_after_xfer, clock, reset, req_xfer, state_ff != S_IDLE)

endmodule

`default_nettype wire

// ===== tb/tb_adc_map_pixel.sv =====
// Self-checking testbench for adc_map_pixel: directed voxel table, then randomized volumes.
`timescale 1ns / 1ps

module tb_adc_map_pixel import adcmp_pkg::*;;

   localparam int LOG_F      = LOG_FRAC_BITS_DEF;
   localparam int N_PHASES   = 8;
   localparam int PHASE_LEN  = 230;
   localparam int HOLD_LEN   = 600;
   localparam int DRAIN_WAIT = 50;

   typedef enum logic {
      ROW_VOXEL,
      ROW_BVAL
   } row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [SAMPLE_W-1:0]   base;
      logic [SAMPLE_W-1:0]   wght;
      logic                  last;
      logic [B_VALUE_W-1:0]  bval;
      logic                  typed;
      logic [ADC_W-1:0]      adc;
      logic [ADC_W-1:0]      peak;
   } dir_row_type;

   typedef struct packed {
      logic [ADC_W-1:0] adc;
      logic [ADC_W-1:0] peak;
      logic             done;
   } px_result_type;

   localparam int DIR_N = 24;
   localparam dir_row_type DIR_ROWS [DIR_N] = '{
      '{ROW_VOXEL, 16'd0,     16'd0,     1'b0, 14'd0,     1'b1, 16'd0,     16'd0},
      '{ROW_VOXEL, 16'd0,     16'd65535, 1'b0, 14'd0,     1'b1, 16'd0,     16'd0},
      '{ROW_VOXEL, 16'd65535, 16'd0,     1'b0, 14'd0,     1'b1, 16'd0,     16'd0},
      '{ROW_VOXEL, 16'd100,   16'd100,   1'b0, 14'd0,     1'b1, 16'd0,     16'd0},
      '{ROW_VOXEL, 16'd100,   16'd200,   1'b0, 14'd0,     1'b1, 16'd0,     16'd0},
      '{ROW_VOXEL, 16'd65535, 16'd65535, 1'b1, 14'd0,     1'b1, 16'd0,     16'd0},
      '{ROW_VOXEL, 16'd2,     16'd1,     1'b0, 14'd0,     1'b1, 16'd693,   16'd693},
      '{ROW_VOXEL, 16'd4,     16'd1,     1'b1, 14'd0,     1'b1, 16'd1386,  16'd1386},
      '{ROW_VOXEL, 16'd65535, 16'd1,     1'b0, 14'd0,     1'b0, 16'd0,     16'd0},
      '{ROW_VOXEL, 16'd1,     16'd1,     1'b0, 14'd0,     1'b0, 16'd0,     16'd0},
      '{ROW_VOXEL, 16'd255,   16'd254,   1'b1, 14'd0,     1'b0, 16'd0,     16'd0},
      '{ROW_BVAL,  16'd0,     16'd0,     1'b0, 14'd16383, 1'b0, 16'd0,     16'd0},
      '{ROW_VOXEL, 16'd65535, 16'd1,     1'b0, 14'd0,     1'b1, 16'd65535, 16'd65535},
      '{ROW_VOXEL, 16'd2,     16'd1,     1'b0, 14'd0,     1'b0, 16'd0,     16'd0},
      '{ROW_VOXEL, 16'd65535, 16'd32768, 1'b1, 14'd0,     1'b0, 16'd0,     16'd0},
      '{ROW_BVAL,  16'd0,     16'd0,     1'b0, 14'd0,     1'b0, 16'd0,     16'd0},
      '{ROW_VOXEL, 16'd65535, 16'd1,     1'b0, 14'd0,     1'b1, 16'd0,     16'd0},
      '{ROW_VOXEL, 16'd12345, 16'd7,     1'b1, 14'd0,     1'b1, 16'd0,     16'd0},
      '{ROW_BVAL,  16'd0,     16'd0,     1'b0, 14'd1,     1'b0, 16'd0,     16'd0},
      '{ROW_VOXEL, 16'd65535, 16'd1,     1'b0, 14'd0,     1'b0, 16'd0,     16'd0},
      '{ROW_VOXEL, 16'd2,     16'd1,     1'b1, 14'd0,     1'b0, 16'd0,     16'd0},
      '{ROW_BVAL,  16'd0,     16'd0,     1'b0, 14'd8191,  1'b0, 16'd0,     16'd0},
      '{ROW_VOXEL, 16'd43690, 16'd21845, 1'b0, 14'd0,     1'b0, 16'd0,     16'd0},
      '{ROW_VOXEL, 16'd21845, 16'd43690, 1'b1, 14'd0,     1'b0, 16'd0,     16'd0}
   };

   logic clock;
   logic reset;

   adcmp_req_if req_if ();
   adcmp_rsp_if rsp_if ();
   adcmp_csr_if csr_if ();

   adc_map_pixel DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   px_result_type         pending_px [$];
   logic [B_VALUE_W-1:0]  cur_bval;
   logic [ADC_W-1:0]      vol_peak;
   int                    fail_count;
   bit                    hold_request;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   // Q4.F log2 of a nonzero sample by repeated squaring of the Q1.30 mantissa
   function automatic logic [63:0] lg_fixed(input logic [SAMPLE_W-1:0] x);
      int unsigned e;
      logic [63:0] m;
      logic [63:0] frac;
      e = 0;
      while (e < 15 && (x >> (e + 1)) != 0)
         e++;
      m = 64'(x) << (30 - e);
      frac = '0;
      repeat (LOG_F) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= 64'h8000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return (64'(e) << LOG_F) | frac;
   endfunction

   function automatic logic [ADC_W-1:0] calc_adc(input logic [SAMPLE_W-1:0] b_in,
                                                input logic [SAMPLE_W-1:0] w_in,
                                                input logic [B_VALUE_W-1:0] bv);
      logic [SAMPLE_W-1:0] b;
      logic [SAMPLE_W-1:0] w;
      logic [63:0] lb;
      logic [63:0] lw;
      logic [63:0] d;
      logic [63:0] ln_q;
      logic [63:0] r;
      b = b_in & SAMPLE_W'((1 << SAMPLE_BITS_DEF) - 1);
      w = w_in & SAMPLE_W'((1 << SAMPLE_BITS_DEF) - 1);
      if (b == 0 || w == 0)
         return '0;
      if (w > b)
         w = b;
      lb = lg_fixed(b);
      lw = lg_fixed(w);
      d = (lb > lw) ? lb - lw : 64'd0;
      ln_q = (d * 64'(LN2_Q32)) >> 32;
      r = (64'(bv) * ln_q) >> LOG_F;
      return (r > 64'(ADC_MAX)) ? ADC_MAX : r[ADC_W-1:0];
   endfunction

   task automatic send_voxel(input logic [SAMPLE_W-1:0] b, input logic [SAMPLE_W-1:0] w,
                             input logic lst, input logic typed,
                             input logic [ADC_W-1:0] t_adc, input logic [ADC_W-1:0] t_peak);
      px_result_type res;
      logic [ADC_W-1:0] a;
      req_if.valid           <= 1'b1;
      req_if.baseline_sample <= b;
      req_if.weighted_sample <= w;
      req_if.last_voxel      <= lst;
      do @(posedge clock); while (!req_if.ready);
      a = calc_adc(b, w, cur_bval);
      if (a > vol_peak)
         vol_peak = a;
      res.adc  = typed ? t_adc : a;
      res.peak = typed ? t_peak : vol_peak;
      res.done = lst;
      pending_px = {pending_px, res};
      if (lst)
         vol_peak = '0;
   endtask

   task automatic drain_results();
      while (pending_px.size() != 0)
         @(posedge clock);
   endtask

   // only called with the block idle
   task automatic write_bval(input logic [B_VALUE_W-1:0] v);
      csr_if.valid   <= 1'b1;
      csr_if.b_value <= v;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      cur_bval = v;
   endtask

   always @(posedge clock) begin
      px_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_px.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("ERROR: unexpected result adc=%0d max=%0d done=%0d",
                        rsp_if.adc_value, rsp_if.running_max, rsp_if.volume_done);
         end else begin
            want = pending_px.pop_front();
            if (rsp_if.adc_value !== want.adc || rsp_if.running_max !== want.peak ||
                rsp_if.volume_done !== want.done) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("ERROR: exp adc=%0d max=%0d done=%0d, got adc=%0d max=%0d done=%0d",
                           want.adc, want.peak, want.done, rsp_if.adc_value,
                           rsp_if.running_max, rsp_if.volume_done);
            end
         end
      end
   end

   // receiver stall pattern, plus one long hold-off to back the block up
   initial begin
      int seg_left;
      int seg_mode;
      int tick;
      bit hold_done;
      seg_left  = 0;
      seg_mode  = 0;
      tick      = 0;
      hold_done = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_request && !hold_done) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            if (seg_left == 0) begin
               seg_mode = $urandom_range(0, 3);
               seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            case (seg_mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= 1'($urandom_range(0, 1));
               2: rsp_if.ready <= (tick % 4 == 0);
               default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      logic [SAMPLE_W-1:0]  b;
      logic [SAMPLE_W-1:0]  w;
      logic                 lst;
      logic [B_VALUE_W-1:0] bv;
      int burst_left;
      fail_count   = 0;
      hold_request = 1'b0;
      cur_bval     = B_VALUE_RESET;
      vol_peak     = '0;
      reset                  <= 1'b1;
      req_if.valid           <= 1'b0;
      req_if.baseline_sample <= '0;
      req_if.weighted_sample <= '0;
      req_if.last_voxel      <= 1'b0;
      csr_if.valid           <= 1'b0;
      csr_if.b_value         <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_N; i++) begin
         if (DIR_ROWS[i].kind == ROW_BVAL) begin
            req_if.valid <= 1'b0;
            drain_results();
            write_bval(DIR_ROWS[i].bval);
         end else begin
            send_voxel(DIR_ROWS[i].base, DIR_ROWS[i].wght, DIR_ROWS[i].last,
                       DIR_ROWS[i].typed, DIR_ROWS[i].adc, DIR_ROWS[i].peak);
         end
      end

      for (int ph = 0; ph < N_PHASES; ph++) begin
         req_if.valid <= 1'b0;
         drain_results();
         case (ph)
            0: bv = 14'd16383;
            1: bv = 14'd0;
            2: bv = 14'd1;
            default: bv = B_VALUE_W'($urandom_range(0, 16383));
         endcase
         write_bval(bv);
         burst_left = $urandom_range(1, 24);
         for (int n = 0; n < PHASE_LEN; n++) begin
            if (ph == 3 && n == 20)
               hold_request = 1'b1;
            case ($urandom_range(0, 9))
               0: begin
                  b = SAMPLE_W'($urandom);
                  w = SAMPLE_W'($urandom);
               end
               1: begin
                  b = SAMPLE_W'($urandom);
                  w = '0;
               end
               2: begin
                  b = '0;
                  w = SAMPLE_W'($urandom);
               end
               3: begin
                  b = SAMPLE_W'($urandom);
                  w = b;
               end
               4: begin
                  b = SAMPLE_W'($urandom_range(0, 65534));
                  w = SAMPLE_W'($urandom_range(int'(b) + 1, 65535));
               end
               7: begin
                  b = SAMPLE_W'($urandom_range(1, 64));
                  w = SAMPLE_W'($urandom_range(1, int'(b)));
               end
               8: begin
                  b = SAMPLE_W'($urandom_range(32768, 65535));
                  w = SAMPLE_W'($urandom_range(1, 16));
               end
               9: begin
                  b = SAMPLE_W'($urandom_range(4, 65535));
                  w = b - SAMPLE_W'($urandom_range(1, 3));
               end
               default: begin
                  b = SAMPLE_W'($urandom_range(1, 65535));
                  w = SAMPLE_W'($urandom_range(1, int'(b)));
               end
            endcase
            lst = ($urandom_range(0, 15) == 0);
            send_voxel(b, w, lst, 1'b0, '0, '0);
            burst_left--;
            if (burst_left == 0) begin
               req_if.valid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 200)
                                                        : $urandom_range(1, 24);
            end
         end
      end

      req_if.valid <= 1'b0;
      drain_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && pending_px.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/adcmp_pkg.sv
sv/adcmp_if.sv
sv/adc_map_pixel.sv
tb/tb_adc_map_pixel.sv
